// ----- rtl/invpp_pkg.sv -----
`default_nettype none

package invpp_pkg;

  // entry layout: 4 type bytes then 32 hash bytes
  localparam int unsigned TYPE_BYTES  = 4;
  localparam int unsigned HASH_BYTES  = 32;
  localparam int unsigned ENTRY_BYTES = TYPE_BYTES + HASH_BYTES;
  localparam int unsigned TYPE_IDX_W  = $clog2(TYPE_BYTES);
  localparam int unsigned HASH_IDX_W  = $clog2(HASH_BYTES);
  localparam int unsigned POS_W       = 6;

  // compactsize prefix markers
  localparam logic [7:0] PFX_U16 = 8'hFD;
  localparam logic [7:0] PFX_U32 = 8'hFE;
  localparam logic [7:0] PFX_U64 = 8'hFF;

  localparam logic [3:0] PFX_LEN_U16 = 4'd2;
  localparam logic [3:0] PFX_LEN_U32 = 4'd4;
  localparam logic [3:0] PFX_LEN_U64 = 4'd8;

  localparam logic [15:0] MAX_ENTRIES_RST = 16'd50000;

  // result queue
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_PREFIX  = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_ENTRIES = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_COUNT_BAD     = 3'd1,
    ST_OVER_LIMIT    = 3'd2,
    ST_ENTRIES_TRUNC = 3'd3,
    ST_TRAILING      = 3'd4
  } status_e;

  typedef enum logic {
    RK_ENTRY  = 1'b0,
    RK_STATUS = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                       kind;
    logic [31:0]                 entry_type;
    logic [HASH_BYTES-1:0][7:0]  hash;
    status_e                     status;
    logic                        last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/inventory_payload_parser.sv -----
`default_nettype none

// channel   direction  handshake                   payload
// --------  ---------  --------------------------  ---------------------------------------
// in        sink       in_valid_i / in_stall_o      payload_byte, end_of_payload, empty_payload
// out       source     out_valid_o / out_stall_i    result_kind, entry_type, hash_word0..3,
//                                                   status_code, last_result
// cfg       sink       cfg_valid_i / cfg_ready_o    cfg_data_i = max_entries
//
// one payload byte per cycle while in_stall_o is low: the parse state updates in the cycle of the transfer and
// its results are registered into a four-deep result queue that drives the out side
// a byte that closes an entry and the message at once yields two results (entry, status)
// in_stall_o rises when fewer than two queue slots are free, so input only waits on a
// stalled output side; with out_stall_i low the block runs at one byte per cycle
// rst_ni clears the parse state and the queue and sets max_entries to 50000

module inventory_payload_parser
  import invpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic        end_of_payload_i,
  input  wire logic        empty_payload_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [31:0]      entry_type_o,
  output logic [63:0]      hash_word0_o,
  output logic [63:0]      hash_word1_o,
  output logic [63:0]      hash_word2_o,
  output logic [63:0]      hash_word3_o,
  output logic [2:0]       status_code_o,
  output logic             last_result_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  // limit register
  logic [15:0] max_q;

  // parse state
  phase_e                      phase_q, phase_d;
  logic [3:0]                  pfx_left_q, pfx_left_d;
  logic [15:0]                 cnt_lo_q, cnt_lo_d;   // low 16 bits of the count
  logic                        cnt_hi_q, cnt_hi_d;   // any count bit above 15 set
  logic [15:0]                 ent_left_q, ent_left_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [TYPE_BYTES-1:0][7:0]  type_q, type_d;
  logic [HASH_BYTES-1:0][7:0]  hash_q, hash_d;
  status_e                     err_q, err_d;

  // byte-level working values
  logic                        in_xfer;
  logic                        cnt_done;
  logic [15:0]                 cnt_lo_fin;
  logic                        cnt_hi_fin;
  logic [TYPE_BYTES-1:0][7:0]  type_upd;
  logic [HASH_BYTES-1:0][7:0]  hash_upd;
  logic [HASH_IDX_W-1:0]       hash_idx;
  logic                        ent_push;
  logic                        stat_push;
  status_e                     stat_code;
  result_t                     ent_res, stat_res, res0, res1;
  logic [1:0]                  push_n;

  // result queue
  result_t                     oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]         wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [OQ_CNT_W-1:0]         oq_cnt_q;
  logic                        out_xfer;
  result_t                     head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = oq_cnt_q > OQ_CNT_W'(OQ_DEPTH - 2);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = oq_cnt_q != '0;
  assign out_xfer    = out_valid_o && !out_stall_i;

  assign hash_idx = HASH_IDX_W'(pos_q - POS_W'(TYPE_BYTES));

  always_comb begin
    phase_d    = phase_q;
    pfx_left_d = pfx_left_q;
    cnt_lo_d   = cnt_lo_q;
    cnt_hi_d   = cnt_hi_q;
    ent_left_d = ent_left_q;
    pos_d      = pos_q;
    type_d     = type_q;
    hash_d     = hash_q;
    err_d      = err_q;

    cnt_done   = 1'b0;
    cnt_lo_fin = cnt_lo_q;
    cnt_hi_fin = cnt_hi_q;
    type_upd   = type_q;
    hash_upd   = hash_q;
    ent_push   = 1'b0;
    stat_push  = 1'b0;
    stat_code  = ST_OK;

    if (pos_q < POS_W'(TYPE_BYTES)) begin
      type_upd[pos_q[TYPE_IDX_W-1:0]] = payload_byte_i;
    end else begin
      hash_upd[hash_idx] = payload_byte_i;
    end

    if (in_xfer && !empty_payload_i) begin
      case (phase_q)
        PH_PREFIX: begin
          if (payload_byte_i < PFX_U16) begin
            cnt_done   = 1'b1;
            cnt_lo_fin = {8'h00, payload_byte_i};
            cnt_hi_fin = 1'b0;
          end else begin
            if (payload_byte_i == PFX_U16) begin
              pfx_left_d = PFX_LEN_U16;
            end else if (payload_byte_i == PFX_U32) begin
              pfx_left_d = PFX_LEN_U32;
            end else begin
              pfx_left_d = PFX_LEN_U64;
            end
            cnt_lo_d = '0;
            cnt_hi_d = 1'b0;
            pos_d    = '0;
            phase_d  = PH_COUNT;
          end
        end
        PH_COUNT: begin
          // little-endian count; bytes past the second only matter as nonzero
          if (pos_q == POS_W'(0)) begin
            cnt_lo_fin[7:0] = payload_byte_i;
          end else if (pos_q == POS_W'(1)) begin
            cnt_lo_fin[15:8] = payload_byte_i;
          end else begin
            cnt_hi_fin = cnt_hi_q || (payload_byte_i != 8'h00);
          end
          cnt_lo_d   = cnt_lo_fin;
          cnt_hi_d   = cnt_hi_fin;
          pos_d      = pos_q + POS_W'(1);
          pfx_left_d = pfx_left_q - 4'd1;
          cnt_done   = pfx_left_q == 4'd1;
        end
        PH_ENTRIES: begin
          if (pos_q == POS_W'(ENTRY_BYTES - 1)) begin
            ent_push   = 1'b1;
            type_d     = '0;
            hash_d     = '0;
            pos_d      = '0;
            ent_left_d = ent_left_q - 16'd1;
            if (ent_left_q == 16'd1) begin
              phase_d = PH_DONE;
            end
          end else begin
            type_d = type_upd;
            hash_d = hash_upd;
            pos_d  = pos_q + POS_W'(1);
          end
        end
        PH_DONE: begin
          err_d   = ST_TRAILING;
          phase_d = PH_ERROR;
        end
        default: ;
      endcase

      if (cnt_done) begin
        if (cnt_hi_fin || (cnt_lo_fin > max_q)) begin
          err_d   = ST_OVER_LIMIT;
          phase_d = PH_ERROR;
        end else begin
          ent_left_d = cnt_lo_fin;
          pos_d      = '0;
          phase_d    = (cnt_lo_fin == 16'd0) ? PH_DONE : PH_ENTRIES;
        end
      end
    end

    // closing status, then back to a fresh message
    if (in_xfer && (empty_payload_i || end_of_payload_i)) begin
      stat_push = 1'b1;
      if (err_d != ST_OK) begin
        stat_code = err_d;
      end else begin
        case (phase_d)
          PH_PREFIX, PH_COUNT: stat_code = ST_COUNT_BAD;
          PH_ENTRIES:          stat_code = ST_ENTRIES_TRUNC;
          default:             stat_code = ST_OK;
        endcase
      end
      phase_d    = PH_PREFIX;
      pfx_left_d = '0;
      cnt_lo_d   = '0;
      cnt_hi_d   = 1'b0;
      ent_left_d = '0;
      pos_d      = '0;
      type_d     = '0;
      hash_d     = '0;
      err_d      = ST_OK;
    end
  end

  always_comb begin
    ent_res            = '0;
    ent_res.kind       = RK_ENTRY;
    ent_res.entry_type = type_upd;
    ent_res.hash       = hash_upd;
    ent_res.status     = ST_OK;
    ent_res.last       = 1'b0;

    stat_res           = '0;
    stat_res.kind      = RK_STATUS;
    stat_res.status    = stat_code;
    stat_res.last      = 1'b1;

    // entry first when one byte yields both
    res0   = ent_push ? ent_res : stat_res;
    res1   = stat_res;
    push_n = {1'b0, ent_push} + {1'b0, stat_push};
  end

  assign wr_ptr1 = wr_ptr_q + OQ_PTR_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= MAX_ENTRIES_RST;
      phase_q    <= PH_PREFIX;
      pfx_left_q <= '0;
      cnt_lo_q   <= '0;
      cnt_hi_q   <= 1'b0;
      ent_left_q <= '0;
      pos_q      <= '0;
      type_q     <= '0;
      hash_q     <= '0;
      err_q      <= ST_OK;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      oq_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
      phase_q    <= phase_d;
      pfx_left_q <= pfx_left_d;
      cnt_lo_q   <= cnt_lo_d;
      cnt_hi_q   <= cnt_hi_d;
      ent_left_q <= ent_left_d;
      pos_q      <= pos_d;
      type_q     <= type_d;
      hash_q     <= hash_d;
      err_q      <= err_d;
      wr_ptr_q   <= wr_ptr_q + OQ_PTR_W'(push_n);
      rd_ptr_q   <= rd_ptr_q + OQ_PTR_W'(out_xfer);
      oq_cnt_q   <= oq_cnt_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(out_xfer);
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      if ((push_n != 2'd0) && (wr_ptr_q == OQ_PTR_W'(i))) begin
        oq_q[i] <= res0;
      end else if ((push_n == 2'd2) && (wr_ptr1 == OQ_PTR_W'(i))) begin
        oq_q[i] <= res1;
      end
    end
  end

  assign head          = oq_q[rd_ptr_q];
  assign result_kind_o = head.kind;
  assign entry_type_o  = head.entry_type;
  assign hash_word0_o  = head.hash[7:0];
  assign hash_word1_o  = head.hash[15:8];
  assign hash_word2_o  = head.hash[23:16];
  assign hash_word3_o  = head.hash[31:24];
  assign status_code_o = head.status;
  assign last_result_o = head.last;

`ifndef SYNTH
  a_oq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overflow");

  a_close_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (empty_payload_i || end_of_payload_i)) |=> out_valid_o)
    else $error("closing status not queued");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (empty_payload_i || end_of_payload_i)) |=>
      (phase_q == PH_PREFIX) && (err_q == ST_OK) && (pos_q == '0))
    else $error("message state not cleared after status");

  a_err_in_error_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK) |-> (phase_q == PH_ERROR))
    else $error("error code outside error phase");

  a_pos_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(ENTRY_BYTES))
    else $error("entry byte position out of range");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb;
  import invpp_pkg::*;

  // one row of the directed table: a single input transfer and, on rows that close a
  // message with an obvious outcome, the closing status written in by hand
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       emp;
    logic       fixed;
    status_e    want;
  } stim_row_t;

  localparam int unsigned IDLE_LIMIT    = 5000;  // cycles with no transfer on any channel
  localparam int unsigned PHASE_BYTES   = 120;   // random bytes per limit setting
  localparam int unsigned MIN_RESULTS   = 60;
  localparam int unsigned SETTLE_CYCLES = 4;     // results reach the queue in the cycle after the byte

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  payload_byte_i   = 8'h00;
  logic        end_of_payload_i = 1'b0;
  logic        empty_payload_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        result_kind_o;
  logic [31:0] entry_type_o;
  logic [63:0] hash_word0_o;
  logic [63:0] hash_word1_o;
  logic [63:0] hash_word2_o;
  logic [63:0] hash_word3_o;
  logic [2:0]  status_code_o;
  logic        last_result_o;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i       = 16'h0000;

  inventory_payload_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .end_of_payload_i (end_of_payload_i),
    .empty_payload_i  (empty_payload_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .entry_type_o     (entry_type_o),
    .hash_word0_o     (hash_word0_o),
    .hash_word1_o     (hash_word1_o),
    .hash_word2_o     (hash_word2_o),
    .hash_word3_o     (hash_word3_o),
    .status_code_o    (status_code_o),
    .last_result_o    (last_result_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // parser model: own copy of the limit register and of the per-message parse state
  // ---------------------------------------------------------------------------------------
  logic [15:0]                limit_model;
  phase_e                     pm_phase;
  logic [3:0]                 pm_pfx_left;
  logic [63:0]                pm_count;
  logic [15:0]                pm_left;
  logic [5:0]                 pm_pos;      // entry byte index, also count byte index
  logic [31:0]                pm_type;
  logic [HASH_BYTES-1:0][7:0] pm_hash;
  status_e                    pm_err;      // ST_OK while no error has been seen

  result_t     pending_results [$];  // decoded entries and statuses not yet seen on out
  int unsigned results_queued = 0;
  int unsigned fed_bytes      = 0;    // input transfers that the parser acts on
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_left     = 0;
  bit          quiet          = 1'b0;  // no idling on either side for this message
  logic [7:0]  msg_bytes [$];          // message under construction

  // the first messages after reset, sent under the reset limit of 50000
  stim_row_t directed_rows [0:23] = '{
    // empty payload straight after reset: nothing to count
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_COUNT_BAD},
    // zero count, message complete right after it
    '{8'h00, 1'b1, 1'b0, 1'b1, ST_OK},
    // payload ends inside a two-byte count
    '{PFX_U16, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b1, ST_COUNT_BAD},
    // four-byte count of all ones, far over the limit
    '{PFX_U32, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b1, 1'b0, 1'b1, ST_OVER_LIMIT},
    // byte after a complete empty list
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hAB, 1'b1, 1'b0, 1'b1, ST_TRAILING},
    // payload ends two bytes into the first entry
    '{8'h02, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h11, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h22, 1'b1, 1'b0, 1'b1, ST_ENTRIES_TRUNC},
    // empty mark in mid-message: its byte is not taken
    '{8'h01, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h5A, 1'b0, 1'b1, 1'b1, ST_ENTRIES_TRUNC},
    // both end marks: the empty mark wins, the zero byte is not a count
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_COUNT_BAD},
    // non-minimal zero count
    '{PFX_U16, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b1, ST_OK},
    // 50001, one past the limit, then a byte that is ignored
    '{PFX_U16, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h51, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hC3, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h7E, 1'b1, 1'b0, 1'b1, ST_OVER_LIMIT}
  };

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("tb: %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic clear_parse_model();
    pm_phase    = PH_PREFIX;
    pm_pfx_left = '0;
    pm_count    = '0;
    pm_left     = '0;
    pm_pos      = '0;
    pm_type     = '0;
    pm_hash     = '0;
    pm_err      = ST_OK;
  endtask

  task automatic queue_result(input result_t r);
    pending_results = {pending_results, r};
    results_queued++;
  endtask

  // count is complete: check it against the limit and pick the next phase
  task automatic count_done(input logic [63:0] c);
    if (c > {48'd0, limit_model}) begin
      pm_err   = ST_OVER_LIMIT;
      pm_phase = PH_ERROR;
    end else begin
      pm_left  = c[15:0];
      pm_pos   = '0;
      pm_phase = (c == 64'd0) ? PH_DONE : PH_ENTRIES;
    end
  endtask

  // one accepted input transfer: advance the model, queue whatever results it yields
  task automatic model_parse(input logic [7:0] b, input logic eop, input logic emp);
    status_e st;
    if (emp || pm_phase != PH_ERROR)
      fed_bytes++;
    if (!emp) begin
      case (pm_phase)
        PH_PREFIX: begin
          if (b < PFX_U16) begin
            count_done({56'd0, b});
          end else begin
            pm_pfx_left = (b == PFX_U16) ? PFX_LEN_U16 :
                          (b == PFX_U32) ? PFX_LEN_U32 : PFX_LEN_U64;
            pm_count    = '0;
            pm_pos      = '0;
            pm_phase    = PH_COUNT;
          end
        end
        PH_COUNT: begin
          // count bytes arrive little-endian
          pm_count    = pm_count | ({56'd0, b} << (8 * pm_pos[2:0]));
          pm_pos      = pm_pos + 6'd1;
          pm_pfx_left = pm_pfx_left - 4'd1;
          if (pm_pfx_left == 4'd0)
            count_done(pm_count);
        end
        PH_ENTRIES: begin
          if (pm_pos < TYPE_BYTES)
            pm_type[8 * pm_pos[1:0] +: 8] = b;
          else
            pm_hash[pm_pos - TYPE_BYTES] = b;
          if (pm_pos == ENTRY_BYTES - 1) begin
            queue_result('{kind: RK_ENTRY, entry_type: pm_type, hash: pm_hash,
                           status: ST_OK, last: 1'b0});
            pm_type = '0;
            pm_hash = '0;
            pm_pos  = '0;
            pm_left = pm_left - 16'd1;
            if (pm_left == 16'd0)
              pm_phase = PH_DONE;
          end else begin
            pm_pos = pm_pos + 6'd1;
          end
        end
        PH_DONE: begin
          pm_err   = ST_TRAILING;
          pm_phase = PH_ERROR;
        end
        default: ;
      endcase
    end
    if (emp || eop) begin
      // first error wins; otherwise the status follows from where the bytes stopped
      if (pm_err != ST_OK)
        st = pm_err;
      else if (pm_phase == PH_PREFIX || pm_phase == PH_COUNT)
        st = ST_COUNT_BAD;
      else if (pm_phase == PH_ENTRIES)
        st = ST_ENTRIES_TRUNC;
      else
        st = ST_OK;
      queue_result('{kind: RK_STATUS, entry_type: '0, hash: '0, status: st, last: 1'b1});
      clear_parse_model();
    end
  endtask

  // idle length: mostly none, often a few cycles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // drive one input transfer and hold it until accepted; called right after a rising edge
  task automatic send_item(input logic [7:0] b, input logic eop, input logic emp);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    payload_byte_i   <= b;
    end_of_payload_i <= eop;
    empty_payload_i  <= emp;
    do @(posedge clk_i); while (in_stall_o);
    model_parse(b, eop, emp);
  endtask

  // let every expected result drain, plus the cycles a byte with no result may still need
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_model = v;
  endtask

  // one more byte at the tail of the message under construction
  task automatic add_byte(input logic [7:0] v);
    msg_bytes = {msg_bytes, v};
  endtask

  // count in compactsize form, sometimes wider than needed
  task automatic append_count(input logic [63:0] c);
    int unsigned lvl, enc, nb, k;
    if (c < 64'd253)
      lvl = 0;
    else if (c <= 64'hFFFF)
      lvl = 1;
    else if (c <= 64'hFFFF_FFFF)
      lvl = 2;
    else
      lvl = 3;
    enc = ($urandom_range(0, 2) == 0) ? $urandom_range(lvl, 3) : lvl;
    nb  = 0;
    case (enc)
      0: add_byte(c[7:0]);
      1: begin add_byte(PFX_U16); nb = 2; end
      2: begin add_byte(PFX_U32); nb = 4; end
      default: begin add_byte(PFX_U64); nb = 8; end
    endcase
    for (k = 0; k < nb; k++)
      add_byte(c[8 * k +: 8]);
  endtask

  // one 36-byte entry: random, all zeros or all ones
  task automatic append_entry();
    int unsigned fill, k;
    fill = $urandom_range(0, 9);
    for (k = 0; k < ENTRY_BYTES; k++) begin
      if (fill == 0)
        add_byte(8'h00);
      else if (fill == 1)
        add_byte(8'hFF);
      else
        add_byte(8'($urandom));
    end
  endtask

  // build and send one message: mostly well formed, the rest cut, padded, over or noise
  task automatic send_message();
    int unsigned form, n, cut, end_kind, i;
    logic [63:0] c;
    bit tail_mark;
    msg_bytes.delete();
    quiet = ($urandom_range(0, 6) == 0);
    form  = $urandom_range(0, 99);
    n     = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
    if (n > limit_model)
      n = {16'd0, limit_model};
    if (form < 85) begin
      append_count(64'(n));
      repeat (n) append_entry();
      if (form >= 65 && form < 75) begin
        // cut short anywhere, down to nothing at all
        cut = $urandom_range(0, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (form >= 75) begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
    end else if (form < 93) begin
      // over the limit: one past it, or a wild 64-bit count
      c = (form < 89) ? {48'd0, limit_model} + 64'd1 : {$urandom, $urandom};
      append_count(c);
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 40)) add_byte(8'($urandom));
    end
    // close on the last byte, or by an extra transfer with the empty mark
    end_kind  = $urandom_range(0, 9);
    tail_mark = (msg_bytes.size() != 0 && end_kind >= 2);
    for (i = 0; i < msg_bytes.size(); i++)
      send_item(msg_bytes[i], tail_mark && i == msg_bytes.size() - 1, 1'b0);
    if (!tail_mark)
      send_item(8'($urandom), end_kind == 1, 1'b1);
  endtask

  // ---------------------------------------------------------------------------------------
  // output side: random stall bursts, skipped while a quiet message is running
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  // every result transfer is checked against the oldest expected one, field by field
  always @(posedge clk_i) begin : result_check
    result_t      want;
    logic [255:0] want_hash;
    logic [63:0]  got_hash [4];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected", {63'd0, result_kind_o},
                        64'd0);
      end else begin
        want        = pending_results.pop_front();
        want_hash   = want.hash;
        got_hash[0] = hash_word0_o;
        got_hash[1] = hash_word1_o;
        got_hash[2] = hash_word2_o;
        got_hash[3] = hash_word3_o;
        if (result_kind_o !== want.kind)
          report_mismatch("result_kind", {63'd0, result_kind_o}, {63'd0, want.kind});
        if (entry_type_o !== want.entry_type)
          report_mismatch("entry_type", {32'd0, entry_type_o}, {32'd0, want.entry_type});
        for (int k = 0; k < 4; k++) begin
          if (got_hash[k] !== want_hash[64 * k +: 64])
            report_mismatch($sformatf("hash_word%0d", k), got_hash[k], want_hash[64 * k +: 64]);
        end
        if (status_code_o !== want.status)
          report_mismatch("status_code", {61'd0, status_code_o}, {61'd0, want.status});
        if (last_result_o !== want.last)
          report_mismatch("last_result", {63'd0, last_result_o}, {63'd0, want.last});
      end
    end
  end

  // watchdog: too long without a transfer on any channel means the block hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("inventory_payload_parser: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // main sequence: reset, directed table, then random messages under several limits
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   row;
    result_t     closing;
    logic [15:0] lim;
    int unsigned phase_start;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    limit_model = MAX_ENTRIES_RST;
    clear_parse_model();
    @(posedge clk_i);

    // directed table; a hand-written status replaces the model's on closing rows
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.data, row.eop, row.emp);
      if (row.fixed) begin
        closing         = pending_results.pop_back();
        closing.status  = row.want;
        pending_results = {pending_results, closing};
      end
    end

    // limit extremes first, then small limits, then the reset limit
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0:       lim = 16'd0;
        1:       lim = 16'hFFFF;
        2:       lim = 16'd1;
        3:       lim = 16'($urandom_range(2, 400));
        4:       lim = 16'd3;
        default: lim = MAX_ENTRIES_RST;
      endcase
      write_limit(lim);
      phase_start = fed_bytes;
      while (fed_bytes - phase_start < PHASE_BYTES) send_message();
    end
    while (results_queued < MIN_RESULTS) send_message();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);
    if (mismatch_count == 0)
      $display("inventory_payload_parser: match");
    else
      $display("inventory_payload_parser: mismatch");
    $finish;
  end

endmodule
